### design/vtt_pkg.sv
// Shared widths, payload structs and pipeline tag types for the vector_towards_2d block.
package vtt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;
	localparam int DW        = CW + 1;
	localparam int MAGW      = CW;
	localparam int SQW       = 2 * MAGW;
	localparam int RADW      = SQW + 2;
	localparam int ROOTW     = RADW / 2;
	localparam int REMW      = ROOTW + 2;
	localparam int QW        = FRAC_BITS + 1;
	localparam int PRODW     = CW + QW;
	localparam int SMAGW     = PRODW - FRAC_BITS;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] dist_req;
	} vtt_in_t;

	typedef struct packed {
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic [ROOTW-1:0]     span;
		logic                 zero_span;
	} vtt_out_t;

	typedef struct packed {
		logic [MAGW-1:0] mx;
		logic [MAGW-1:0] my;
		logic            x_neg;
		logic            y_neg;
		logic [CW-1:0]   dmag;
		logic            d_neg;
		logic            zero;
	} vtt_sq_tag_t;

	typedef struct packed {
		logic [ROOTW-1:0] span;
		logic             x_neg;
		logic             y_neg;
		logic [CW-1:0]    dmag;
		logic             d_neg;
		logic             zero;
	} vtt_div_tag_t;

endpackage

### design/vtt_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per register stage.
module vtt_sqrt
	import vtt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [RADW-1:0]  rad,
	input  vtt_sq_tag_t      in_tag,
	output logic             out_valid,
	output logic [ROOTW-1:0] root,
	output vtt_sq_tag_t      out_tag
);

	logic              vld_s  [ROOTW];
	logic [RADW-1:0]   rad_s  [ROOTW];
	logic [REMW-1:0]   rem_s  [ROOTW];
	logic [ROOTW-1:0]  root_s [ROOTW];
	vtt_sq_tag_t       tag_s  [ROOTW];

	logic [RADW-1:0]   rad_n  [ROOTW];
	logic [REMW-1:0]   rem_n  [ROOTW];
	logic [ROOTW-1:0]  root_n [ROOTW];

	always_comb begin
		logic [RADW-1:0]  prad;
		logic [REMW-1:0]  prem;
		logic [ROOTW-1:0] proot;
		logic [REMW-1:0]  cur;
		logic [REMW-1:0]  trial;
		for (int k = 0; k < ROOTW; k++) begin
			if (k == 0) begin
				prad  = rad;
				prem  = '0;
				proot = '0;
			end else begin
				prad  = rad_s[k-1];
				prem  = rem_s[k-1];
				proot = root_s[k-1];
			end
			cur   = {prem[REMW-3:0], prad[RADW-1:RADW-2]};
			trial = {proot, 2'b01};
			if (cur >= trial) begin
				rem_n[k]  = cur - trial;
				root_n[k] = {proot[ROOTW-2:0], 1'b1};
			end else begin
				rem_n[k]  = cur;
				root_n[k] = {proot[ROOTW-2:0], 1'b0};
			end
			rad_n[k] = {prad[RADW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOTW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < ROOTW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			for (int k = 0; k < ROOTW; k++) begin
				rad_s[k]  <= rad_n[k];
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
			end
			for (int k = 1; k < ROOTW; k++) tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_valid = vld_s[ROOTW-1];
	assign root      = root_s[ROOTW-1];
	assign out_tag   = tag_s[ROOTW-1];

endmodule

### design/vtt_div.sv
// Pipelined restoring divider forming both unit-vector components, one quotient bit per stage.
module vtt_div
	import vtt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [MAGW-1:0]  mx,
	input  logic [MAGW-1:0]  my,
	input  vtt_div_tag_t     in_tag,
	output logic             out_valid,
	output logic [QW-1:0]    qx,
	output logic [QW-1:0]    qy,
	output vtt_div_tag_t     out_tag
);

	logic              vld_s  [QW];
	logic [ROOTW:0]    remx_s [QW];
	logic [ROOTW:0]    remy_s [QW];
	logic [QW-1:0]     lowx_s [QW];
	logic [QW-1:0]     lowy_s [QW];
	logic [QW-1:0]     qx_s   [QW];
	logic [QW-1:0]     qy_s   [QW];
	vtt_div_tag_t      tag_s  [QW];

	logic [ROOTW:0]    remx_n [QW];
	logic [ROOTW:0]    remy_n [QW];
	logic [QW-1:0]     lowx_n [QW];
	logic [QW-1:0]     lowy_n [QW];
	logic [QW-1:0]     qx_n   [QW];
	logic [QW-1:0]     qy_n   [QW];

	always_comb begin
		logic [ROOTW:0]   prx, pry, cx, cy, dv;
		logic [QW-1:0]    plx, ply, pqx, pqy;
		logic [ROOTW-1:0] sp;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				prx = {{(ROOTW+2-MAGW){1'b0}}, mx[MAGW-1:1]};
				pry = {{(ROOTW+2-MAGW){1'b0}}, my[MAGW-1:1]};
				plx = {mx[0], {FRAC_BITS{1'b0}}};
				ply = {my[0], {FRAC_BITS{1'b0}}};
				pqx = '0;
				pqy = '0;
				sp  = in_tag.span;
			end else begin
				prx = remx_s[k-1];
				pry = remy_s[k-1];
				plx = lowx_s[k-1];
				ply = lowy_s[k-1];
				pqx = qx_s[k-1];
				pqy = qy_s[k-1];
				sp  = tag_s[k-1].span;
			end
			dv = {1'b0, sp};
			cx = {prx[ROOTW-1:0], plx[QW-1]};
			cy = {pry[ROOTW-1:0], ply[QW-1]};
			if (cx >= dv) begin
				remx_n[k] = cx - dv;
				qx_n[k]   = {pqx[QW-2:0], 1'b1};
			end else begin
				remx_n[k] = cx;
				qx_n[k]   = {pqx[QW-2:0], 1'b0};
			end
			if (cy >= dv) begin
				remy_n[k] = cy - dv;
				qy_n[k]   = {pqy[QW-2:0], 1'b1};
			end else begin
				remy_n[k] = cy;
				qy_n[k]   = {pqy[QW-2:0], 1'b0};
			end
			lowx_n[k] = {plx[QW-2:0], 1'b0};
			lowy_n[k] = {ply[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			for (int k = 0; k < QW; k++) begin
				remx_s[k] <= remx_n[k];
				remy_s[k] <= remy_n[k];
				lowx_s[k] <= lowx_n[k];
				lowy_s[k] <= lowy_n[k];
				qx_s[k]   <= qx_n[k];
				qy_s[k]   <= qy_n[k];
			end
			for (int k = 1; k < QW; k++) tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_valid = vld_s[QW-1];
	assign qx        = qx_s[QW-1];
	assign qy        = qy_s[QW-1];
	assign out_tag   = tag_s[QW-1];

endmodule

### design/vector_towards_2d.sv
// Top level of vector_towards_2d: scaled unit vector from point a toward point b.
// The block takes one item per clock while the output is not held: four stages form
// the difference, magnitudes, squares and their sum, 33 stages take the square root
// one bit each, 17 stages divide both components one quotient bit each, and two
// stages scale by the wanted length and saturate. The whole pipeline stalls
// together while a finished result waits at the output register.
module vector_towards_2d
	import vtt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vtt_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output vtt_out_t out_data
);

	function automatic logic [CW-1:0] sat_apply(input logic [SMAGW-1:0] mag, input logic neg);
		logic [SMAGW-1:0] lim;
		logic [SMAGW-1:0] m;
		begin
			if (neg) begin
				lim = {{(SMAGW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
				m   = (mag > lim) ? lim : mag;
				sat_apply = (~m[CW-1:0]) + {{(CW-1){1'b0}}, 1'b1};
			end else begin
				lim = {{(SMAGW-CW+1){1'b0}}, {(CW-1){1'b1}}};
				m   = (mag > lim) ? lim : mag;
				sat_apply = m[CW-1:0];
			end
		end
	endfunction

	logic en;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [CW-1:0] dist_s1;
	vtt_sq_tag_t          tag_s2, tag_s3, tag_s4;
	logic [SQW-1:0]       sx_s3, sy_s3;
	logic [SQW:0]         sum_s4;

	logic                 sq_valid;
	logic [ROOTW-1:0]     sq_root;
	vtt_sq_tag_t          sq_tag;
	vtt_div_tag_t         dv_in_tag;

	logic                 dv_valid;
	logic [QW-1:0]        dv_qx, dv_qy;
	vtt_div_tag_t         dv_tag;

	logic [PRODW-1:0]     px_s5, py_s5;
	vtt_div_tag_t         tag_s5;

	logic                 vld_q;
	vtt_out_t             out_q;

	assign en       = !vld_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= dv_valid;
			vld_q  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(in_data.bx) - DW'(in_data.ax);
			dy_s1   <= DW'(in_data.by) - DW'(in_data.ay);
			dist_s1 <= in_data.dist_req;

			tag_s2.x_neg <= dx_s1[DW-1];
			tag_s2.y_neg <= dy_s1[DW-1];
			tag_s2.mx    <= dx_s1[DW-1] ? MAGW'(-dx_s1) : MAGW'(dx_s1);
			tag_s2.my    <= dy_s1[DW-1] ? MAGW'(-dy_s1) : MAGW'(dy_s1);
			tag_s2.d_neg <= dist_s1[CW-1];
			tag_s2.dmag  <= dist_s1[CW-1] ? (~dist_s1 + 1'b1) : dist_s1;
			tag_s2.zero  <= (dx_s1 == '0) && (dy_s1 == '0);

			sx_s3  <= tag_s2.mx * tag_s2.mx;
			sy_s3  <= tag_s2.my * tag_s2.my;
			tag_s3 <= tag_s2;

			sum_s4 <= {1'b0, sx_s3} + {1'b0, sy_s3};
			tag_s4 <= tag_s3;

			px_s5  <= dv_tag.dmag * dv_qx;
			py_s5  <= dv_tag.dmag * dv_qy;
			tag_s5 <= dv_tag;

			out_q.span      <= tag_s5.zero ? '0 : tag_s5.span;
			out_q.zero_span <= tag_s5.zero;
			out_q.rx        <= tag_s5.zero ? '0 :
				sat_apply(px_s5[PRODW-1:FRAC_BITS], tag_s5.d_neg ^ tag_s5.x_neg);
			out_q.ry        <= tag_s5.zero ? '0 :
				sat_apply(py_s5[PRODW-1:FRAC_BITS], tag_s5.d_neg ^ tag_s5.y_neg);
		end
	end

	vtt_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.rad       ({1'b0, sum_s4}),
		.in_tag    (tag_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	always_comb begin
		dv_in_tag.span  = sq_root;
		dv_in_tag.x_neg = sq_tag.x_neg;
		dv_in_tag.y_neg = sq_tag.y_neg;
		dv_in_tag.dmag  = sq_tag.dmag;
		dv_in_tag.d_neg = sq_tag.d_neg;
		dv_in_tag.zero  = sq_tag.zero;
	end

	vtt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.mx        (sq_tag.mx),
		.my        (sq_tag.my),
		.in_tag    (dv_in_tag),
		.out_valid (dv_valid),
		.qx        (dv_qx),
		.qy        (dv_qy),
		.out_tag   (dv_tag)
	);

	assign out_valid = vld_q;
	assign out_data  = out_q;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_span |->
			out_data.rx == '0 && out_data.ry == '0 && out_data.span == '0)
		else $error("equal points gave a nonzero result");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.zero_span |-> out_data.span != '0)
		else $error("distinct points gave a zero length");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("waiting result was lost or changed");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_tag.zero |->
			dv_qx <= {1'b1, {FRAC_BITS{1'b0}}} && dv_qy <= {1'b1, {FRAC_BITS{1'b0}}})
		else $error("unit component exceeds one");

endmodule

### tb/sv/vector_towards_2d_test.sv
// Self-checking testbench for vector_towards_2d with a scoreboard that predicts every result.
module vector_towards_2d_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vtt_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 80;

	class heading_board;
		vtt_out_t pending[$];
		int       fails;
		int       checked;
		int       zero_seen;
		int       sat_seen;

		task report(string what);
			$display("MISMATCH @%0t: %s", $realtime, what);
			fails++;
		endtask

		function logic [CW-1:0] scaled(longint len, longint u);
			longint mag;
			mag = ((len < 0 ? -len : len) * (u < 0 ? -u : u)) >>> FRAC_BITS;
			if ((len < 0) != (u < 0)) begin
				if (mag > 64'h8000_0000) begin
					mag = 64'h8000_0000;
				end
				return CW'(-mag);
			end
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
			end
			return CW'(mag);
		endfunction

		function vtt_out_t predict(vtt_in_t it);
			logic [CW+1:0]   dx, dy;
			logic [CW:0]     mx, my, root, cand;
			logic [2*CW+2:0] sq, c2;
			longint          ux, uy;
			vtt_out_t        r;
			dx = {{2{it.bx[CW-1]}}, it.bx} - {{2{it.ax[CW-1]}}, it.ax};
			dy = {{2{it.by[CW-1]}}, it.by} - {{2{it.ay[CW-1]}}, it.ay};
			mx = dx[CW+1] ? (CW+1)'(-dx) : dx[CW:0];
			my = dy[CW+1] ? (CW+1)'(-dy) : dy[CW:0];
			r = '0;
			if (mx == 0 && my == 0) begin
				r.zero_span = 1'b1;
				return r;
			end
			sq = (2*CW+3)'(mx) * (2*CW+3)'(mx) + (2*CW+3)'(my) * (2*CW+3)'(my);
			root = '0;
			for (int b = CW; b >= 0; b--) begin
				cand = root | ((CW+1)'(1) << b);
				c2 = (2*CW+3)'(cand) * (2*CW+3)'(cand);
				if (c2 <= sq) begin
					root = cand;
				end
			end
			ux = longint'((64'(mx) << FRAC_BITS) / 64'(root));
			uy = longint'((64'(my) << FRAC_BITS) / 64'(root));
			if (dx[CW+1]) ux = -ux;
			if (dy[CW+1]) uy = -uy;
			r.rx = scaled(longint'(it.dist_req), ux);
			r.ry = scaled(longint'(it.dist_req), uy);
			r.span = root;
			return r;
		endfunction

		function void note_input(vtt_in_t it);
			pending.push_back(predict(it));
		endfunction

		task check_result(vtt_out_t got);
			vtt_out_t want;
			if (pending.size() == 0) begin
				report("result arrived with none expected");
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.zero_span) zero_seen++;
			if (got.rx == 32'h7FFF_FFFF || got.ry == 32'h7FFF_FFFF) sat_seen++;
			if (got.rx !== want.rx)
				report($sformatf("rx got %h want %h", got.rx, want.rx));
			if (got.ry !== want.ry)
				report($sformatf("ry got %h want %h", got.ry, want.ry));
			if (got.span !== want.span)
				report($sformatf("span got %h want %h", got.span, want.span));
			if (got.zero_span !== want.zero_span)
				report($sformatf("zero_span got %b want %b", got.zero_span, want.zero_span));
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	vtt_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	vtt_out_t out_data;

	heading_board board;
	int           snd_idle;
	int           rcv_idle;
	bit           hold_req;
	int           cycles;
	int           sent;

	vector_towards_2d i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task send(vtt_in_t it);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(negedge clk); while (!in_ready);
		board.note_input(it);
		sent++;
		@(posedge clk);
	endtask

	task send_pts(logic [31:0] ax, ay, bx, by, len);
		vtt_in_t it;
		it.ax = ax;
		it.ay = ay;
		it.bx = bx;
		it.by = by;
		it.dist_req = len;
		send(it);
	endtask

	function logic [31:0] any_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2000) - 1000;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(5)
				: 32'h8000_0000 + $urandom_range(5);
		endcase
	endfunction

	task send_random();
		vtt_in_t it;
		it.ax = any_word();
		it.ay = any_word();
		case ($urandom_range(9))
			0: begin
				it.bx = it.ax;
				it.by = it.ay;
			end
			1, 2, 3: begin
				it.bx = it.ax + $urandom_range(64) - 32;
				it.by = it.ay + $urandom_range(64) - 32;
			end
			default: begin
				it.bx = any_word();
				it.by = any_word();
			end
		endcase
		it.dist_req = any_word();
		send(it);
	endtask

	task wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			repeat (300) @(posedge clk);
			hold_req = 1'b0;
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_data);
		end
	end

	initial begin
		board    = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		hold_req = 1'b0;
		cycles   = 0;
		sent     = 0;
		snd_idle = 32;
		rcv_idle = 53;
		repeat (2) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_pts(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		send_pts(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_pts(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pts(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h0001_0000);
		send_pts(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h0001_0000);
		send_pts(5, 0, 4, 0, 32'h8000_0000);
		send_pts(0, 5, 0, 4, 32'h8000_0000);
		send_pts(4, 0, 5, 0, 32'h8000_0000);
		send_pts(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h000A_0000);
		send_pts(0, 0, 32'h0003_0000, 32'h0004_0000, 32'hFFF6_0000);
		send_pts(0, 0, 1, 1, 32'h7FFF_FFFF);
		send_pts(0, 0, 1, 1, 0);
		send_pts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
		send_pts(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555);

		for (int i = 0; i < 130; i++) send_random();
		snd_idle = 53;
		rcv_idle = 32;
		for (int i = 0; i < 130; i++) send_random();
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 140; i++) send_random();
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (board.pending.size() != 0)
			board.report($sformatf("%0d results never arrived", board.pending.size()));
		$display("Sent %0d items and checked %0d results, %0d with equal points,",
			sent, board.checked, board.zero_seen);
		$display("%0d saturated, under random sender and receiver stalls.", board.sat_seen);
		if (board.fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### vector_towards_2d.f
design/vtt_pkg.sv
design/vtt_sqrt.sv
design/vtt_div.sv
design/vector_towards_2d.sv
tb/sv/vector_towards_2d_test.sv
